@@ rtl/fpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Front-light probe and fault controller package
// Shared types, command and mode codes, and the percent-to-duty scaling.
// ----------------------------------------------------------------------------
package fpfc_pkg;

  // Duty resolution of the PWM channels and the full-scale duty.
  localparam int DUTY_BITS = 8;
  localparam int FULL_DUTY = (1 << DUTY_BITS) - 1;

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 8;
  localparam int PCT_W   = 7;
  localparam int COUNT_W = 16;
  localparam int DUTY_W  = 8;
  localparam int CFG_W   = 16;
  localparam int INDEX_W = 2;

  localparam logic [PCT_W-1:0]   PCT_MAX    = PCT_W'(100);
  localparam logic [PCT_W-1:0]   BRIGHT_RST = PCT_W'(10);
  localparam logic [PCT_W-1:0]   TEMP_RST   = PCT_W'(50);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  // Division by 100 through a reciprocal multiply. The shift leaves an error
  // below 1/128 over the whole product range, so the floor is exact.
  localparam int PROD_W      = DUTY_BITS + PCT_W;
  localparam int RECIP_SHIFT = PROD_W + 7;
  localparam int RECIP_W     = RECIP_SHIFT - 6;
  localparam int RECIP       = (1 << RECIP_SHIFT) / 100 + 1;
  localparam int QUOT_W      = PROD_W + RECIP_W;

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    REG_MIN_BRIGHT = 2'd0,
    REG_PROBE_TO   = 2'd1,
    REG_SETTLE     = 2'd2
  } reg_index_t;

  // Input commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ENABLE  = 3'd1,
    CMD_DISABLE = 3'd2,
    CMD_BRIGHT  = 3'd3,
    CMD_TEMP    = 3'd4
  } cmd_t;

  // Supervisor modes, reported as mode_status.
  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_PROBE  = 3'd1,
    MODE_SETTLE = 3'd2,
    MODE_ARMED  = 3'd3,
    MODE_FAULT  = 3'd4
  } mode_t;

  // Floor of pct * FULL_DUTY / 100, truncated to the duty field.
  function automatic logic [DUTY_W-1:0] scale_pct(input logic [PCT_W-1:0] pct);
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    prod = PROD_W'(pct) * PROD_W'(FULL_DUTY);
    quot = QUOT_W'(prod) * QUOT_W'(RECIP);
    return DUTY_W'(quot >> RECIP_SHIFT);
  endfunction

endpackage

@@ rtl/frontlight_probe_fault_controller.sv @@
// ----------------------------------------------------------------------------
// Front-light probe and fault controller
// Supervises the LED rail: probes regulation after enable, waits for the
// settle time, then watches the sense line for a fault.
// ----------------------------------------------------------------------------
// The result of an accepted item is loaded into the output register at the edge that accepts it.
// Throughput: one item per cycle while the input is not stalled; the supervisor state
// and the result register are both updated at the edge that accepts the item.
// The input is stalled only while a held result is itself stalled.
// Reset (rst, synchronous): mode off, rail off, no fault, brightness 10 %,
// colour temperature 50 %, sense history high, registers at their defaults.
module frontlight_probe_fault_controller (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write port
  input  logic                         cfg_write,
  input  logic [fpfc_pkg::INDEX_W-1:0] cfg_index,
  input  logic [fpfc_pkg::CFG_W-1:0]   cfg_data,
  // Item channel
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [fpfc_pkg::CMD_W-1:0]   cmd,
  input  logic [fpfc_pkg::VALUE_W-1:0] value,
  input  logic                         sense_level,
  // Result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         rail_on,
  output logic [fpfc_pkg::DUTY_W-1:0]  bright_duty,
  output logic [fpfc_pkg::DUTY_W-1:0]  warm_duty,
  output logic [fpfc_pkg::DUTY_W-1:0]  cool_duty,
  output logic [2:0]                   mode_status,
  output logic                         fault_flag
);

  // Configuration registers.
  logic [fpfc_pkg::PCT_W-1:0]   bright_floor;
  logic [fpfc_pkg::COUNT_W-1:0] probe_timeout_ticks;
  logic [fpfc_pkg::COUNT_W-1:0] settle_ticks;

  // Supervisor state.
  fpfc_pkg::mode_t              mode, mode_next;
  logic [fpfc_pkg::PCT_W-1:0]   bright_pct, bright_pct_next;
  logic [fpfc_pkg::PCT_W-1:0]   temp_pct, temp_pct_next;
  logic [fpfc_pkg::COUNT_W-1:0] tick_count, tick_count_next;
  logic                         fault_latch, fault_latch_next;
  logic                         rail_state, rail_state_next;
  logic                         prev_sense, prev_sense_next;

  logic                         accept;
  logic [fpfc_pkg::COUNT_W-1:0] count_inc;
  logic                         falling, rising;
  logic [fpfc_pkg::PCT_W-1:0]   val_clamped;
  logic [fpfc_pkg::PCT_W-1:0]   bright_clamped;
  logic [fpfc_pkg::DUTY_W-1:0]  bright_duty_next, warm_duty_next, cool_duty_next;

  // A new item is taken whenever the result register is free or being drained.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      bright_floor        <= fpfc_pkg::PCT_W'(1);
      probe_timeout_ticks <= fpfc_pkg::COUNT_W'(100);
      settle_ticks        <= fpfc_pkg::COUNT_W'(50);
    end else if (cfg_write) begin
      case (cfg_index)
        fpfc_pkg::REG_MIN_BRIGHT: bright_floor        <= cfg_data[fpfc_pkg::PCT_W-1:0];
        fpfc_pkg::REG_PROBE_TO:   probe_timeout_ticks <= cfg_data;
        fpfc_pkg::REG_SETTLE:     settle_ticks        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Percent clamps for the brightness command and the enable.
  always_comb begin
    logic [fpfc_pkg::VALUE_W-1:0] raised;
    raised = (value < fpfc_pkg::VALUE_W'(bright_floor)) ?
             fpfc_pkg::VALUE_W'(bright_floor) : value;
    val_clamped = (raised > fpfc_pkg::VALUE_W'(fpfc_pkg::PCT_MAX)) ?
                  fpfc_pkg::PCT_MAX : raised[fpfc_pkg::PCT_W-1:0];
  end

  always_comb begin
    logic [fpfc_pkg::PCT_W-1:0] raised;
    raised = (bright_pct < bright_floor) ? bright_floor : bright_pct;
    bright_clamped = (raised > fpfc_pkg::PCT_MAX) ? fpfc_pkg::PCT_MAX : raised;
  end

  // Sense edges and the saturating tick counter.
  assign falling   = prev_sense && !sense_level;
  assign rising    = !prev_sense && sense_level;
  assign count_inc = (tick_count == fpfc_pkg::COUNT_MAX) ? tick_count
                                                         : tick_count + 1'b1;

  // Next state for the item being transferred in.
  always_comb begin
    mode_next        = mode;
    bright_pct_next  = bright_pct;
    temp_pct_next    = temp_pct;
    tick_count_next  = tick_count;
    fault_latch_next = fault_latch;
    rail_state_next  = rail_state;
    prev_sense_next  = prev_sense;
    case (cmd)
      fpfc_pkg::CMD_TICK: begin
        prev_sense_next = sense_level;
        case (mode)
          fpfc_pkg::MODE_PROBE: begin
            if (falling) begin
              tick_count_next = '0;
              mode_next = (settle_ticks == '0) ? fpfc_pkg::MODE_ARMED
                                               : fpfc_pkg::MODE_SETTLE;
            end else begin
              tick_count_next = count_inc;
              if (count_inc >= probe_timeout_ticks) begin
                fault_latch_next = 1'b1;
                rail_state_next  = 1'b0;
                mode_next        = fpfc_pkg::MODE_FAULT;
              end
            end
          end
          fpfc_pkg::MODE_SETTLE: begin
            tick_count_next = count_inc;
            if (count_inc >= settle_ticks) begin
              mode_next = fpfc_pkg::MODE_ARMED;
            end
          end
          fpfc_pkg::MODE_ARMED: begin
            if (rising) begin
              fault_latch_next = 1'b1;
              mode_next        = fpfc_pkg::MODE_FAULT;
            end
          end
          default: ;
        endcase
      end
      fpfc_pkg::CMD_ENABLE: begin
        fault_latch_next = 1'b0;
        bright_pct_next  = bright_clamped;
        rail_state_next  = 1'b1;
        tick_count_next  = '0;
        mode_next        = fpfc_pkg::MODE_PROBE;
      end
      fpfc_pkg::CMD_DISABLE: begin
        rail_state_next = 1'b0;
        tick_count_next = '0;
        mode_next       = fpfc_pkg::MODE_OFF;
      end
      fpfc_pkg::CMD_BRIGHT: begin
        bright_pct_next = val_clamped;
      end
      fpfc_pkg::CMD_TEMP: begin
        temp_pct_next = (value > fpfc_pkg::VALUE_W'(fpfc_pkg::PCT_MAX)) ?
                        fpfc_pkg::PCT_MAX : value[fpfc_pkg::PCT_W-1:0];
      end
      default: ;
    endcase
  end

  // Duties for the state after the item.
  always_comb begin
    bright_duty_next = '0;
    warm_duty_next   = '0;
    cool_duty_next   = '0;
    case (mode_next)
      fpfc_pkg::MODE_PROBE: begin
        bright_duty_next = fpfc_pkg::DUTY_W'(fpfc_pkg::FULL_DUTY);
        warm_duty_next   = fpfc_pkg::DUTY_W'(fpfc_pkg::FULL_DUTY);
        cool_duty_next   = fpfc_pkg::DUTY_W'(fpfc_pkg::FULL_DUTY);
      end
      fpfc_pkg::MODE_SETTLE, fpfc_pkg::MODE_ARMED: begin
        bright_duty_next = fpfc_pkg::scale_pct(bright_pct_next);
        warm_duty_next   = fpfc_pkg::scale_pct(temp_pct_next);
        cool_duty_next   = fpfc_pkg::scale_pct(fpfc_pkg::PCT_MAX - temp_pct_next);
      end
      default: ;
    endcase
  end

  // Supervisor state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= fpfc_pkg::MODE_OFF;
      bright_pct  <= fpfc_pkg::BRIGHT_RST;
      temp_pct    <= fpfc_pkg::TEMP_RST;
      tick_count  <= '0;
      fault_latch <= 1'b0;
      rail_state  <= 1'b0;
      prev_sense  <= 1'b1;
    end else if (accept) begin
      mode        <= mode_next;
      bright_pct  <= bright_pct_next;
      temp_pct    <= temp_pct_next;
      tick_count  <= tick_count_next;
      fault_latch <= fault_latch_next;
      rail_state  <= rail_state_next;
      prev_sense  <= prev_sense_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload, loaded on every transfer in.
  always_ff @(posedge clk) begin
    if (accept) begin
      rail_on     <= rail_state_next;
      bright_duty <= bright_duty_next;
      warm_duty   <= warm_duty_next;
      cool_duty   <= cool_duty_next;
      mode_status <= mode_next;
      fault_flag  <= fault_latch_next;
    end
  end

  // A reported fault mode always carries the latched fault.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (mode_status == fpfc_pkg::MODE_FAULT) |-> fault_flag)
    else $error("fault mode reported without the fault flag");

  // Probing always shows a powered rail at full duty.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (mode_status == fpfc_pkg::MODE_PROBE) |->
      rail_on && (bright_duty == fpfc_pkg::DUTY_W'(fpfc_pkg::FULL_DUTY)))
    else $error("probe result without rail or full duty");

  // Off mode shows an unpowered rail and dark channels.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (mode_status == fpfc_pkg::MODE_OFF) |->
      !rail_on && (bright_duty == '0) && (warm_duty == '0) && (cool_duty == '0))
    else $error("off result with rail or duty active");

  // Every item taken in yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result");

endmodule

@@ dv/frontlight_checker.sv @@
// ----------------------------------------------------------------------------
// Front-light supervisor checker
// Watches the configuration port and both channels, keeps its own copy of the
// supervisor state, predicts the result of every accepted item and compares
// each result transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frontlight_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [fpfc_pkg::INDEX_W-1:0] cfg_index,
  input  logic [fpfc_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         item_valid,
  input  logic                         item_stall,
  input  logic [fpfc_pkg::CMD_W-1:0]   cmd,
  input  logic [fpfc_pkg::VALUE_W-1:0] value,
  input  logic                         sense_level,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic                         rail_on,
  input  logic [fpfc_pkg::DUTY_W-1:0]  bright_duty,
  input  logic [fpfc_pkg::DUTY_W-1:0]  warm_duty,
  input  logic [fpfc_pkg::DUTY_W-1:0]  cool_duty,
  input  logic [2:0]                   mode_status,
  input  logic                         fault_flag,
  output int unsigned                  mismatches,
  output int unsigned                  outstanding
);

  // One predicted result transfer.
  typedef struct packed {
    logic                        rail;
    logic [fpfc_pkg::DUTY_W-1:0] bright;
    logic [fpfc_pkg::DUTY_W-1:0] warm;
    logic [fpfc_pkg::DUTY_W-1:0] cool;
    fpfc_pkg::mode_t             mode;
    logic                        fault;
  } lamp_out_t;

  // Shadow copy of the supervisor and its registers.
  fpfc_pkg::mode_t              lamp_mode;
  logic [fpfc_pkg::PCT_W-1:0]   bright_pct;
  logic [fpfc_pkg::PCT_W-1:0]   temp_pct;
  logic [fpfc_pkg::PCT_W-1:0]   min_pct;
  logic [fpfc_pkg::COUNT_W-1:0] tick_cnt;
  logic [fpfc_pkg::COUNT_W-1:0] probe_limit;
  logic [fpfc_pkg::COUNT_W-1:0] settle_len;
  logic                         fault_latched;
  logic                         rail_pwr;
  logic                         last_sense;

  lamp_out_t lamp_q[$];

  // Floor of pct * full-scale / 100.
  function automatic logic [fpfc_pkg::DUTY_W-1:0] duty_of(input int unsigned pct);
    return fpfc_pkg::DUTY_W'((pct * fpfc_pkg::FULL_DUTY) / 100);
  endfunction

  // Brightness is raised to the minimum first, then capped at 100 %.
  function automatic logic [fpfc_pkg::PCT_W-1:0] clamp_level(input int unsigned pct);
    if (pct < min_pct) pct = min_pct;
    if (pct > 100) pct = 100;
    return fpfc_pkg::PCT_W'(pct);
  endfunction

  // Advance the shadow state by one item and queue the expected result.
  task automatic step_lamp(input logic [fpfc_pkg::CMD_W-1:0]   c,
                           input logic [fpfc_pkg::VALUE_W-1:0] v,
                           input logic                         s);
    lamp_out_t want;
    logic      fall;
    logic      rise;
    fall = 1'b0;
    rise = 1'b0;
    case (c)
      fpfc_pkg::CMD_TICK: begin
        fall = last_sense && !s;
        rise = !last_sense && s;
        last_sense = s;
        case (lamp_mode)
          fpfc_pkg::MODE_PROBE: begin
            if (fall) begin
              tick_cnt  = '0;
              lamp_mode = (settle_len == 0) ? fpfc_pkg::MODE_ARMED
                                            : fpfc_pkg::MODE_SETTLE;
            end else begin
              if (tick_cnt != fpfc_pkg::COUNT_MAX) tick_cnt = tick_cnt + 1'b1;
              if (tick_cnt >= probe_limit) begin
                fault_latched = 1'b1;
                rail_pwr      = 1'b0;
                lamp_mode     = fpfc_pkg::MODE_FAULT;
              end
            end
          end
          fpfc_pkg::MODE_SETTLE: begin
            if (tick_cnt != fpfc_pkg::COUNT_MAX) tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= settle_len) lamp_mode = fpfc_pkg::MODE_ARMED;
          end
          fpfc_pkg::MODE_ARMED: begin
            if (rise) begin
              fault_latched = 1'b1;
              lamp_mode     = fpfc_pkg::MODE_FAULT;
            end
          end
          default: ;
        endcase
      end
      fpfc_pkg::CMD_ENABLE: begin
        fault_latched = 1'b0;
        bright_pct    = clamp_level(bright_pct);
        rail_pwr      = 1'b1;
        tick_cnt      = '0;
        lamp_mode     = fpfc_pkg::MODE_PROBE;
      end
      fpfc_pkg::CMD_DISABLE: begin
        rail_pwr  = 1'b0;
        tick_cnt  = '0;
        lamp_mode = fpfc_pkg::MODE_OFF;
      end
      fpfc_pkg::CMD_BRIGHT: bright_pct = clamp_level(v);
      fpfc_pkg::CMD_TEMP:   temp_pct = (v > 100) ? fpfc_pkg::PCT_MAX
                                                 : fpfc_pkg::PCT_W'(v);
      default: ;
    endcase

    want.rail  = rail_pwr;
    want.mode  = lamp_mode;
    want.fault = fault_latched;
    if (lamp_mode == fpfc_pkg::MODE_PROBE) begin
      want.bright = fpfc_pkg::DUTY_W'(fpfc_pkg::FULL_DUTY);
      want.warm   = fpfc_pkg::DUTY_W'(fpfc_pkg::FULL_DUTY);
      want.cool   = fpfc_pkg::DUTY_W'(fpfc_pkg::FULL_DUTY);
    end else if (lamp_mode == fpfc_pkg::MODE_SETTLE ||
                 lamp_mode == fpfc_pkg::MODE_ARMED) begin
      want.bright = duty_of(bright_pct);
      want.warm   = duty_of(temp_pct);
      want.cool   = duty_of(100 - temp_pct);
    end else begin
      want.bright = '0;
      want.warm   = '0;
      want.cool   = '0;
    end
    lamp_q.push_back(want);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Everything is sampled at the rising edge; the block updates its outputs
  // through nonblocking assignments, so the values seen here are pre-edge.
  always @(posedge clk) begin
    lamp_out_t want;
    if (rst) begin
      lamp_mode     = fpfc_pkg::MODE_OFF;
      bright_pct    = fpfc_pkg::BRIGHT_RST;
      temp_pct      = fpfc_pkg::TEMP_RST;
      min_pct       = fpfc_pkg::PCT_W'(1);
      probe_limit   = fpfc_pkg::COUNT_W'(100);
      settle_len    = fpfc_pkg::COUNT_W'(50);
      tick_cnt      = '0;
      fault_latched = 1'b0;
      rail_pwr      = 1'b0;
      last_sense    = 1'b1;
      mismatches    = 0;
      lamp_q.delete();
    end else begin
      if (cfg_write) begin
        case (fpfc_pkg::reg_index_t'(cfg_index))
          fpfc_pkg::REG_MIN_BRIGHT: min_pct = cfg_data[fpfc_pkg::PCT_W-1:0];
          fpfc_pkg::REG_PROBE_TO:   probe_limit = cfg_data[fpfc_pkg::COUNT_W-1:0];
          fpfc_pkg::REG_SETTLE:     settle_len = cfg_data[fpfc_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end

      // A result leaving now belongs to an earlier item, so compare first.
      if (result_valid && !result_stall) begin
        if (lamp_q.size() == 0) begin
          $error("result transfer with no prediction outstanding");
          mismatches++;
        end else begin
          want = lamp_q.pop_front();
          check_field("rail_on", want.rail, rail_on);
          check_field("bright_duty", want.bright, bright_duty);
          check_field("warm_duty", want.warm, warm_duty);
          check_field("cool_duty", want.cool, cool_duty);
          check_field("mode_status", want.mode, mode_status);
          check_field("fault_flag", want.fault, fault_flag);
        end
      end

      if (item_valid && !item_stall) step_lamp(cmd, value, sense_level);
    end
    outstanding = lamp_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Front-light supervisor testbench
// Drives a directed run through timeout, settling, arming and sense faults,
// then random enable sessions and noise under four register settings, with
// random gaps on the item channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SHIFT_A = 317;
  localparam int unsigned SHIFT_B = 634;
  localparam int          PHASES  = 4;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [fpfc_pkg::INDEX_W-1:0]   cfg_index;
  logic [fpfc_pkg::CFG_W-1:0]     cfg_data;
  logic                           item_valid;
  logic                           item_stall;
  logic [fpfc_pkg::CMD_W-1:0]     cmd;
  logic [fpfc_pkg::VALUE_W-1:0]   value;
  logic                           sense_level;
  logic                           result_valid;
  logic                           result_stall;
  logic                           rail_on;
  logic [fpfc_pkg::DUTY_W-1:0]    bright_duty;
  logic [fpfc_pkg::DUTY_W-1:0]    warm_duty;
  logic [fpfc_pkg::DUTY_W-1:0]    cool_duty;
  logic [2:0]                     mode_status;
  logic                           fault_flag;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned items_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  logic        sense_hist;

  // Register settings of the random phases, extremes included.
  int unsigned min_set[PHASES]    = '{0, 100, 37, 1};
  int unsigned probe_set[PHASES]  = '{1, 5, 12, 65535};
  int unsigned settle_set[PHASES] = '{0, 3, 8, 65535};
  int unsigned phase_end[PHASES]  = '{250, 480, 710, 950};

  frontlight_probe_fault_controller i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .cmd         (cmd),
    .value       (value),
    .sense_level (sense_level),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .rail_on     (rail_on),
    .bright_duty (bright_duty),
    .warm_duty   (warm_duty),
    .cool_duty   (cool_duty),
    .mode_status (mode_status),
    .fault_flag  (fault_flag)
  );

  frontlight_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .cmd         (cmd),
    .value       (value),
    .sense_level (sense_level),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .rail_on     (rail_on),
    .bright_duty (bright_duty),
    .warm_duty   (warm_duty),
    .cool_duty   (cool_duty),
    .mode_status (mode_status),
    .fault_flag  (fault_flag),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Idling profile: sender dense and receiver busy, then swapped, then none.
  always_comb begin
    if (items_sent < SHIFT_A) begin
      tx_idle_pct  = 7;
      rx_stall_pct = 52;
    end else if (items_sent < SHIFT_B) begin
      tx_idle_pct  = 52;
      rx_stall_pct = 7;
    end else begin
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
    end
  end

  // Result side stalls at random.
  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < rx_stall_pct);
  end

  // Present one item and hold it until its transfer.
  task automatic send_item(input logic [fpfc_pkg::CMD_W-1:0]   c,
                           input logic [fpfc_pkg::VALUE_W-1:0] v,
                           input logic                         s);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid  <= 1'b1;
    cmd         <= c;
    value       <= v;
    sense_level <= s;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic tick(input logic s);
    send_item(fpfc_pkg::CMD_TICK, fpfc_pkg::VALUE_W'($urandom), s);
    sense_hist = s;
  endtask

  // Percent values, mostly near the legal range.
  function automatic logic [fpfc_pkg::VALUE_W-1:0] pick_pct();
    if ($urandom_range(1) == 0) return fpfc_pkg::VALUE_W'($urandom_range(110));
    return fpfc_pkg::VALUE_W'($urandom);
  endfunction

  task automatic send_setting();
    if ($urandom_range(1) == 0) send_item(fpfc_pkg::CMD_BRIGHT, pick_pct(), 1'($urandom));
    else send_item(fpfc_pkg::CMD_TEMP, pick_pct(), 1'($urandom));
  endtask

  // Registers change only once every prediction has been answered.
  task automatic set_limits(input int unsigned lo_pct, input int unsigned probe_to,
                            input int unsigned settle);
    item_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= fpfc_pkg::REG_MIN_BRIGHT;
    cfg_data  <= fpfc_pkg::CFG_W'(lo_pct);
    @(negedge clk);
    cfg_index <= fpfc_pkg::REG_PROBE_TO;
    cfg_data  <= fpfc_pkg::CFG_W'(probe_to);
    @(negedge clk);
    cfg_index <= fpfc_pkg::REG_SETTLE;
    cfg_data  <= fpfc_pkg::CFG_W'(settle);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One enable cycle: probe (success or timeout), settle, armed watch.
  task automatic run_session(input int unsigned probe_to, input int unsigned settle);
    int unsigned k;
    if ($urandom_range(99) < 30) send_setting();
    // The probe needs a high sense history to see a falling edge.
    if (!sense_hist) tick(1'b1);
    send_item(fpfc_pkg::CMD_ENABLE, fpfc_pkg::VALUE_W'($urandom), 1'($urandom));
    if (probe_to <= 40 && $urandom_range(99) < 25) begin
      repeat (probe_to) tick(1'b1);
    end else begin
      k = $urandom_range((probe_to - 1 < 10) ? probe_to - 1 : 10);
      repeat (k) tick(1'b1);
      tick(1'b0);
      k = (settle < 30) ? settle : 30;
      repeat (k) begin
        if ($urandom_range(99) < 10) send_setting();
        tick(1'($urandom));
      end
      repeat ($urandom_range(15)) begin
        if ($urandom_range(99) < 10) send_setting();
        tick($urandom_range(99) < 12);
      end
    end
    if ($urandom_range(1) == 0)
      send_item(fpfc_pkg::CMD_DISABLE, fpfc_pkg::VALUE_W'($urandom), 1'($urandom));
  endtask

  // Run guard.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = fpfc_pkg::REG_MIN_BRIGHT;
    cfg_data    = '0;
    item_valid  = 1'b0;
    cmd         = fpfc_pkg::CMD_TICK;
    value       = '0;
    sense_level = 1'b1;
    items_sent  = 0;
    sense_hist  = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: short probe timeout and settle time, minimum above the
    // reset brightness so that enable has to raise it.
    set_limits(20, 3, 2);
    send_item(fpfc_pkg::CMD_ENABLE, 8'h00, 1'b0);
    tick(1'b1);
    tick(1'b1);
    tick(1'b1);
    // Unused command codes change nothing.
    for (int c = int'(fpfc_pkg::CMD_TEMP) + 1; c < (1 << fpfc_pkg::CMD_W); c++)
      send_item(fpfc_pkg::CMD_W'(c), 8'hFF, 1'b1);
    send_item(fpfc_pkg::CMD_BRIGHT, 8'h00, 1'b0);
    send_item(fpfc_pkg::CMD_BRIGHT, 8'hFF, 1'b1);
    send_item(fpfc_pkg::CMD_TEMP, 8'hFF, 1'b1);
    send_item(fpfc_pkg::CMD_TEMP, 8'h00, 1'b0);
    // Enable clears the fault; falling edge, settle with an ignored rising
    // edge, then a rising edge while armed.
    send_item(fpfc_pkg::CMD_ENABLE, 8'hFF, 1'b1);
    tick(1'b0);
    tick(1'b1);
    tick(1'b0);
    tick(1'b0);
    tick(1'b1);
    // Sense fault keeps the rail; disable keeps the fault latch.
    send_item(fpfc_pkg::CMD_TEMP, 8'd100, 1'b0);
    send_item(fpfc_pkg::CMD_DISABLE, 8'hFF, 1'b1);
    tick(1'b0);
    send_item(fpfc_pkg::CMD_BRIGHT, 8'd100, 1'b1);

    // Random phases.
    for (int p = 0; p < PHASES; p++) begin
      set_limits(min_set[p], probe_set[p], settle_set[p]);
      while (items_sent < phase_end[p]) begin
        if ($urandom_range(99) < 25) begin
          repeat ($urandom_range(4, 1))
            send_item(fpfc_pkg::CMD_W'($urandom), fpfc_pkg::VALUE_W'($urandom),
                      1'($urandom));
          sense_hist = 1'b0;
        end
        run_session(probe_set[p], settle_set[p]);
      end
    end

    item_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
